// ----- rtl/csd_pkg.sv -----
`timescale 1ns / 1ps

package csd_pkg;

    // phase table geometry
    localparam int HALF_TABLE_ENTRIES = 128;
    localparam int ROM_SIZE           = 128;
    localparam int ROM_IDX_W          = $clog2(ROM_SIZE);
    localparam int PHASE_W            = $clog2(2 * HALF_TABLE_ENTRIES);
    localparam int POS_W              = $clog2(HALF_TABLE_ENTRIES);
    localparam int IDX_PROD_W         = POS_W + ROM_IDX_W + 1;

    // report pacing, an interval of zero acts as one
    localparam int REPORT_INTERVAL = 3;
    localparam int RPT_EFF         = (REPORT_INTERVAL < 1) ? 1 : REPORT_INTERVAL;
    localparam int RPT_W           = (RPT_EFF < 2) ? 1 : $clog2(RPT_EFF);

    // dac frame control bits
    localparam logic [7:0] DAC_CTRL_BITS = 8'b0011_0000;
    localparam logic [7:0] DAC_GAIN_BIT  = 8'h10;
    localparam logic [7:0] MIRROR_TOP    = 8'd254;

    // adc scaling
    localparam int          ADC_W        = 10;
    localparam logic [10:0] ADC_FULL     = 11'd1023;
    localparam logic [10:0] MON_RECIP    = 11'd1639;
    localparam int          MON_SHIFT    = 13;

    // bound reset values
    localparam logic [6:0] LOWER_RESET = 7'd63;
    localparam logic [7:0] UPPER_RESET = 8'd191;
    localparam logic [7:0] UPPER_TOP   = 8'd255;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADC  = 1'b1;

    typedef enum logic [1:0] {
        CHAN_POT1 = 2'd0,
        CHAN_POT2 = 2'd1,
        CHAN_MON  = 2'd2
    } t_adc_chan;

    typedef struct packed {
        logic [15:0] spi_frame;
        logic [7:0]  dac_value;
        logic        report_due;
        logic        monitor_valid;
        logic [8:0]  monitor_scaled;
        logic [6:0]  lower_bound_now;
        logic [7:0]  upper_bound_now;
    } t_result;

    // half sine, floor(127.5 + 127.5*sin(pi*i/128))
    localparam logic [7:0] SINE_ROM [ROM_SIZE] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130
    };

    // floor(x / 1023) for x below 2^17: shift estimate plus one correction
    function automatic logic [7:0] div_1023(input logic [16:0] x);
        logic [6:0]  q0;
        logic [10:0] rem;
        begin
            q0  = x[16:10];
            rem = {1'b0, x[9:0]} + {4'b0, q0};
            div_1023 = {1'b0, q0} + ((rem >= ADC_FULL) ? 8'd1 : 8'd0);
        end
    endfunction

endpackage

// ----- rtl/csd_ifs.sv -----
`timescale 1ns / 1ps

// sample / adc command channel
interface csd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] adc_high;
    logic [7:0] adc_low;

    modport source (output valid, output command, output adc_high, output adc_low,
                    input ready);
    modport sink   (input valid, input command, input adc_high, input adc_low,
                    output ready);
endinterface

// result channel
interface csd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] spi_frame;
    logic [7:0]  dac_value;
    logic        report_due;
    logic        monitor_valid;
    logic [8:0]  monitor_scaled;
    logic [6:0]  lower_bound_now;
    logic [7:0]  upper_bound_now;

    modport source (output valid, output spi_frame, output dac_value, output report_due,
                    output monitor_valid, output monitor_scaled,
                    output lower_bound_now, output upper_bound_now, input ready);
    modport sink   (input valid, input spi_frame, input dac_value, input report_due,
                    input monitor_valid, input monitor_scaled,
                    input lower_bound_now, input upper_bound_now, output ready);
endinterface

// configuration write channel
interface csd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/clipped_sine_dac_generator.sv -----
`timescale 1ns / 1ps

// the result word is registered at the edge that accepts the input word
// throughput: one word per cycle while the skid entry is empty; a two-entry output stage (result + skid) keeps
//   input ready high while one finished result waits
// reset: synchronous active low; clears phase and report count, sets channel (monitor first),
//   bounds 63/191 and right-justified mode, and empties both output stages
module clipped_sine_dac_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csd_in_if.sink        i_in,
    csd_out_if.source     o_out,
    csd_cfg_if.sink       i_cfg
);

    logic [csd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [csd_pkg::RPT_W-1:0]   r_rpt, n_rpt;
    csd_pkg::t_adc_chan          r_chan, n_chan;
    logic [6:0]                  r_lower, n_lower;
    logic [7:0]                  r_upper, n_upper;
    logic                        r_adc_rj;

    logic                        r_out_valid, r_skid_valid;
    csd_pkg::t_result            r_out, r_skid, n_res;

    logic                        in_fire, out_fire, out_free;

    logic                        second_half;
    logic [csd_pkg::POS_W-1:0]   pos;
    logic [csd_pkg::ROM_IDX_W-1:0] rom_idx;
    logic [7:0]                  rom_val, sample, clipped;
    logic                        report;
    logic [csd_pkg::ADC_W-1:0]   raw;
    logic [16:0]                 pot1_prod, pot2_prod;
    logic [7:0]                  pot1_q, pot2_q;
    logic [21:0]                 mon_prod;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && !r_skid_valid;
    assign out_fire    = r_out_valid && o_out.ready;
    assign out_free    = out_fire || !r_out_valid;

    // sample lookup with mirrored second half, clipped to the bounds
    always_comb begin
        second_half = (r_phase >= csd_pkg::PHASE_W'(csd_pkg::HALF_TABLE_ENTRIES));
        pos = second_half
            ? csd_pkg::POS_W'(r_phase - csd_pkg::PHASE_W'(csd_pkg::HALF_TABLE_ENTRIES))
            : csd_pkg::POS_W'(r_phase);
        rom_idx = csd_pkg::ROM_IDX_W'(
            (csd_pkg::IDX_PROD_W'(pos) * csd_pkg::IDX_PROD_W'(csd_pkg::ROM_SIZE))
            / csd_pkg::IDX_PROD_W'(csd_pkg::HALF_TABLE_ENTRIES));
        rom_val = csd_pkg::SINE_ROM[rom_idx];
        if (!second_half) begin
            sample = rom_val;
        end else begin
            sample = (rom_val > csd_pkg::MIRROR_TOP) ? 8'd0 : (csd_pkg::MIRROR_TOP - rom_val);
        end
        if (sample < {1'b0, r_lower}) begin
            clipped = {1'b0, r_lower};
        end else if (sample > r_upper) begin
            clipped = r_upper;
        end else begin
            clipped = sample;
        end
    end

    // adc justification and scaling
    always_comb begin
        raw = r_adc_rj ? {i_in.adc_high[1:0], i_in.adc_low}
                       : {i_in.adc_high, i_in.adc_low[7:6]};
        pot1_prod = {raw, 7'b0} - {7'b0, raw};
        pot2_prod = {raw, 7'b0};
        pot1_q    = csd_pkg::div_1023(pot1_prod);
        pot2_q    = csd_pkg::div_1023(pot2_prod);
        mon_prod  = {11'b0, raw, 1'b0} * {11'b0, csd_pkg::MON_RECIP};
    end

    // next state and result word
    always_comb begin
        n_phase = r_phase;
        n_rpt   = r_rpt;
        n_chan  = r_chan;
        n_lower = r_lower;
        n_upper = r_upper;
        report  = 1'b0;
        n_res   = '0;
        if (i_in.command == csd_pkg::CMD_TICK) begin
            if (r_rpt == csd_pkg::RPT_W'(csd_pkg::RPT_EFF - 1)) begin
                n_rpt  = '0;
                report = 1'b1;
            end else begin
                n_rpt = r_rpt + csd_pkg::RPT_W'(1);
            end
            if (r_phase == csd_pkg::PHASE_W'(2 * csd_pkg::HALF_TABLE_ENTRIES - 1)) begin
                n_phase = '0;
            end else begin
                n_phase = r_phase + csd_pkg::PHASE_W'(1);
            end
            n_res.dac_value  = clipped;
            n_res.spi_frame  = {csd_pkg::DAC_CTRL_BITS | csd_pkg::DAC_GAIN_BIT
                                | {4'b0, clipped[7:4]}, clipped[3:0], 4'b0};
            n_res.report_due = report;
        end else begin
            unique case (r_chan)
                csd_pkg::CHAN_POT1: begin
                    n_lower = pot1_q[6:0];
                    n_chan  = csd_pkg::CHAN_POT2;
                end
                csd_pkg::CHAN_POT2: begin
                    n_upper = csd_pkg::UPPER_TOP - pot2_q;
                    n_chan  = csd_pkg::CHAN_MON;
                end
                default: begin
                    n_res.monitor_valid  = 1'b1;
                    n_res.monitor_scaled = mon_prod[csd_pkg::MON_SHIFT +: 9];
                    n_chan               = csd_pkg::CHAN_POT1;
                end
            endcase
        end
        n_res.lower_bound_now = n_lower;
        n_res.upper_bound_now = n_upper;
    end

    // control state and output stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_rpt        <= '0;
            r_chan       <= csd_pkg::CHAN_MON;
            r_lower      <= csd_pkg::LOWER_RESET;
            r_upper      <= csd_pkg::UPPER_RESET;
            r_adc_rj     <= 1'b1;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_adc_rj <= i_cfg.data;
            end
            if (in_fire) begin
                r_phase <= n_phase;
                r_rpt   <= n_rpt;
                r_chan  <= n_chan;
                r_lower <= n_lower;
                r_upper <= n_upper;
            end
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result and skid payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_res;
            end
        end else if (in_fire) begin
            r_skid <= n_res;
        end
    end

    // result channel
    assign o_out.valid           = r_out_valid;
    assign o_out.spi_frame       = r_out.spi_frame;
    assign o_out.dac_value       = r_out.dac_value;
    assign o_out.report_due      = r_out.report_due;
    assign o_out.monitor_valid   = r_out.monitor_valid;
    assign o_out.monitor_scaled  = r_out.monitor_scaled;
    assign o_out.lower_bound_now = r_out.lower_bound_now;
    assign o_out.upper_bound_now = r_out.upper_bound_now;

endmodule

// ----- rtl/csd_checker.sv -----
`timescale 1ns / 1ps

module csd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_spi_frame,
    input logic [7:0]  i_dac_value,
    input logic        i_monitor_valid,
    input logic [8:0]  i_monitor_scaled,
    input logic [6:0]  i_lower_bound_now,
    input logic [7:0]  i_upper_bound_now
);

    // no result word right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_spi_frame)
            && $stable(i_dac_value) && $stable(i_monitor_scaled))
        else $error("stalled result changed");

    // a tick word carries no monitor reading
    a_tick_no_mon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_spi_frame != 16'd0 |-> !i_monitor_valid && i_monitor_scaled == 9'd0)
        else $error("tick word with monitor reading");

    // the sent sample lies within the clip bounds and matches the frame
    a_tick_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_spi_frame != 16'd0 |->
            i_dac_value >= {1'b0, i_lower_bound_now} && i_dac_value <= i_upper_bound_now
            && i_spi_frame[11:4] == i_dac_value && i_spi_frame[3:0] == 4'd0)
        else $error("tick sample outside bounds or frame mismatch");

endmodule

bind clipped_sine_dac_generator csd_checker u_csd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_spi_frame       (o_out.spi_frame),
    .i_dac_value       (o_out.dac_value),
    .i_monitor_valid   (o_out.monitor_valid),
    .i_monitor_scaled  (o_out.monitor_scaled),
    .i_lower_bound_now (o_out.lower_bound_now),
    .i_upper_bound_now (o_out.upper_bound_now)
);
